>>> rtl/abs_pkg.sv
`default_nettype none

package abs_pkg;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> rtl/abs_cell.sv
`default_nettype none

module abs_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  abs_pkg::t_cell_ctrl          i_ctrl,
    input  wire signed [DATA_WIDTH-1:0]  i_x,
    input  wire signed [DATA_WIDTH-1:0]  i_left_val,
    input  wire                          i_left_vld,
    input  wire                          i_left_gt,
    input  wire signed [DATA_WIDTH-1:0]  i_right_val,
    input  wire                          i_right_vld,
    output logic signed [DATA_WIDTH-1:0] o_val,
    output logic                         o_vld,
    output logic                         o_gt
);
    import abs_pkg::*;

    logic signed [DATA_WIDTH-1:0] r_val;
    logic signed [DATA_WIDTH-1:0] n_val;
    logic                         r_vld;
    logic                         n_vld;

    assign o_gt  = !r_vld || (i_x < r_val);
    assign o_val = r_val;
    assign o_vld = r_vld;

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        if (i_ctrl.shift) begin
            n_val = i_right_val;
            n_vld = i_right_vld;
        end else if (i_ctrl.insert && o_gt) begin
            if (i_left_gt) begin
                n_val = i_left_val;
                n_vld = i_left_vld;
            end else begin
                n_val = i_x;
                n_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ascending_bubble_sorter.sv
// Channel  Dir  Handshake               Payload
// s        in   i_s_tvalid/o_s_tready   i_s_tdata: value; i_s_tlast: last_in
// m        out  o_m_tvalid/i_m_tready   o_m_tdata: sorted_value; o_m_tlast: last_out;
//                                       o_m_tuser: overflow
// Fill: one item per cycle, each inserted in place by a row of compare cells.
// Drain: after the marked item, the row shifts toward cell 0 once per taken item,
// so the set leaves in ascending order from cell 0; input is held off until the last is taken.
// Reset clears the valid bits, the count, the overflow flag and the drain state.
// A stall on the output holds the row and the presented item.
`default_nettype none

module ascending_bubble_sorter #(
    parameter int MAX_ELEMENTS = 64,
    parameter int DATA_WIDTH   = 32
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire [((DATA_WIDTH+7)/8)*8-1:0]           i_s_tdata,  // value
    input  wire                                      i_s_tlast,
    output logic                                     o_m_tvalid,
    input  wire                                      i_m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]          o_m_tdata,  // sorted_value
    output logic                                     o_m_tlast,
    output logic                                     o_m_tuser   // overflow
);
    import abs_pkg::*;

    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
    localparam logic ST_FILL  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                         r_state;
    logic                         n_state;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic                         r_ovf;
    logic                         n_ovf;
    logic                         w_in_acc;
    logic                         w_out_acc;
    logic                         w_full;
    logic signed [DATA_WIDTH-1:0] w_x;
    t_cell_ctrl                   w_ctrl;

    logic signed [DATA_WIDTH-1:0] w_val [MAX_ELEMENTS];
    logic                         w_vld [MAX_ELEMENTS];
    logic                         w_gt  [MAX_ELEMENTS];

    assign w_x       = i_s_tdata[DATA_WIDTH-1:0];
    assign w_full    = (r_count == CNT_W'(MAX_ELEMENTS));
    assign o_s_tready = (r_state == ST_FILL);
    assign w_in_acc  = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_state == ST_DRAIN);
    assign w_out_acc = o_m_tvalid && i_m_tready;

    assign w_ctrl.insert = w_in_acc && !w_full;
    assign w_ctrl.shift  = w_out_acc;

    assign o_m_tdata = TDATA_W'($unsigned(w_val[0]));
    assign o_m_tlast = (r_count == CNT_W'(1));
    assign o_m_tuser = r_ovf;

    for (genvar gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_cell
        logic signed [DATA_WIDTH-1:0] w_lval;
        logic                         w_lvld;
        logic                         w_lgt;
        logic signed [DATA_WIDTH-1:0] w_rval;
        logic                         w_rvld;

        if (gi == 0) begin : g_first
            assign w_lval = '0;
            assign w_lvld = 1'b0;
            assign w_lgt  = 1'b0;
        end else begin : g_mid_l
            assign w_lval = w_val[gi-1];
            assign w_lvld = w_vld[gi-1];
            assign w_lgt  = w_gt[gi-1];
        end

        if (gi == MAX_ELEMENTS - 1) begin : g_last
            assign w_rval = '0;
            assign w_rvld = 1'b0;
        end else begin : g_mid_r
            assign w_rval = w_val[gi+1];
            assign w_rvld = w_vld[gi+1];
        end

        abs_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_x         (w_x),
            .i_left_val  (w_lval),
            .i_left_vld  (w_lvld),
            .i_left_gt   (w_lgt),
            .i_right_val (w_rval),
            .i_right_vld (w_rvld),
            .o_val       (w_val[gi]),
            .o_vld       (w_vld[gi]),
            .o_gt        (w_gt[gi])
        );
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        case (r_state)
            ST_FILL: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_s_tlast) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_out_acc) begin
                    n_count = r_count - CNT_W'(1);
                    if (o_m_tlast) begin
                        n_ovf   = 1'b0;
                        n_state = ST_FILL;
                    end
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

endmodule

`default_nettype wire
